// File: rtl/core/amsc_pkg.sv
// Shared types, constants and codes of the accelerometer step counter.
package amsc_pkg;

   localparam int WINDOW      = 5;
   localparam int SLOT_W      = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int ACCEL_W     = 16;
   localparam int NUM_AXES    = 3;
   localparam int SUM_W       = ACCEL_W + 1 + $clog2(WINDOW);
   localparam int RECIP_SHIFT = SUM_W + 1;
   localparam int RECIP_W     = RECIP_SHIFT + 1;
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((2 ** RECIP_SHIFT) / WINDOW);
   localparam int MEAN_W      = ACCEL_W + 1;
   localparam int SQ_W        = 2 * MEAN_W;
   localparam int RAD_W       = SQ_W + 2;
   localparam int ROOT_W      = RAD_W / 2;
   localparam int ITER_W      = $clog2(ROOT_W + 1);

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam int COUNT_W     = 20;
   localparam logic [COUNT_W-1:0] COUNT_MAX  = '1;
   localparam logic [COUNT_W-1:0] SUB_AMOUNT = COUNT_W'(500);
   localparam logic [COUNT_W-1:0] ADD_AMOUNT = COUNT_W'(100);

   localparam int THRESH_W    = 16;
   localparam int STRIDE_W    = 4;
   localparam logic [THRESH_W-1:0] THRESH_RESET = THRESH_W'(300);
   localparam logic [STRIDE_W-1:0] STRIDE_RESET = STRIDE_W'(9);

   localparam int MAG_W       = 16;
   localparam int DIST_W      = 24;
   localparam int KIND_W      = 2;
   localparam int REQ_DATA_W  = NUM_AXES * ACCEL_W;
   localparam int RSP_DATA_W  = 64;
   localparam int RSP_PAD_W   = RSP_DATA_W - (MAG_W + 1 + COUNT_W + DIST_W);
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;

   typedef enum logic [KIND_W-1:0] {
      KIND_SAMPLE,
      KIND_CLEAR,
      KIND_SUB,
      KIND_ADD
   } kind_type;

   typedef enum logic {
      REG_STEP_THRESHOLD,
      REG_STRIDE_LENGTH
   } reg_index_type;

   typedef struct packed {
      logic                              is_sample;
      kind_type                          kind;
      logic [NUM_AXES-1:0][ACCEL_W-1:0]  accel;
   } item_type;

   typedef struct packed {
      logic [DIST_W-1:0]  distance;
      logic [COUNT_W-1:0] step_total;
      logic               step_detected;
      logic [MAG_W-1:0]   magnitude;
   } result_type;

   typedef struct packed {
      logic [THRESH_W-1:0] step_threshold;
      logic [STRIDE_W-1:0] stride_length;
   } cfg_type;

   typedef struct packed {
      logic             start;
      logic [RAD_W-1:0] radicand;
   } sqrt_req_type;

   typedef struct packed {
      logic              done;
      logic [ROOT_W-1:0] root;
   } sqrt_rsp_type;

endpackage

// File: rtl/core/amsc_csr.sv
// Configuration registers behind the APB-style port.
module amsc_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [amsc_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [amsc_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [amsc_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready,
   output amsc_pkg::cfg_type                 cfg
);

   logic [amsc_pkg::THRESH_W-1:0] thr_ff;
   logic [amsc_pkg::STRIDE_W-1:0] stride_ff;
   amsc_pkg::reg_index_type       reg_idx;
   logic                          wr_en;

   assign reg_idx    = amsc_pkg::reg_index_type'(csr_paddr[2]);
   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff    <= amsc_pkg::THRESH_RESET;
         stride_ff <= amsc_pkg::STRIDE_RESET;
      end else if (wr_en) begin
         unique case (reg_idx)
            amsc_pkg::REG_STEP_THRESHOLD: thr_ff    <= csr_pwdata[amsc_pkg::THRESH_W-1:0];
            amsc_pkg::REG_STRIDE_LENGTH:  stride_ff <= csr_pwdata[amsc_pkg::STRIDE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         amsc_pkg::REG_STEP_THRESHOLD: csr_prdata = amsc_pkg::CSR_DATA_W'(thr_ff);
         amsc_pkg::REG_STRIDE_LENGTH:  csr_prdata = amsc_pkg::CSR_DATA_W'(stride_ff);
         default:                      csr_prdata = '0;
      endcase
   end

   assign cfg.step_threshold = thr_ff;
   assign cfg.stride_length  = stride_ff;

endmodule

// File: rtl/core/amsc_front.sv
// Input side: accept transfers, classify the kind and queue items for the back end.
module amsc_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [amsc_pkg::KIND_W-1:0]       req_tuser,
   input  logic [amsc_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic                              pop,
   output logic                              item_valid,
   output amsc_pkg::item_type                item
);

   amsc_pkg::item_type            queue_ff [amsc_pkg::QUEUE_DEPTH];
   logic [amsc_pkg::QPTR_W-1:0]   wr_ptr_ff;
   logic [amsc_pkg::QPTR_W-1:0]   rd_ptr_ff;
   logic [amsc_pkg::QCNT_W-1:0]   count_ff;
   amsc_pkg::item_type            entry_in;
   logic                          push;
   logic                          take;

   assign req_tready = (count_ff != amsc_pkg::QCNT_W'(amsc_pkg::QUEUE_DEPTH));
   assign item_valid = (count_ff != '0);
   assign item       = queue_ff[rd_ptr_ff];
   assign push       = req_tvalid && req_tready;
   assign take       = pop && item_valid;

   always_comb begin
      entry_in.kind      = amsc_pkg::kind_type'(req_tuser);
      entry_in.is_sample = (entry_in.kind == amsc_pkg::KIND_SAMPLE);
      entry_in.accel     = req_tdata;
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= entry_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (take) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !take) begin
            count_ff <= count_ff + 1'b1;
         end else if (take && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

// File: rtl/core/amsc_sqrt.sv
// Bit-serial floor square root, one root bit per cycle.
module amsc_sqrt (
   input  logic                   clock,
   input  logic                   reset,
   input  amsc_pkg::sqrt_req_type req,
   output amsc_pkg::sqrt_rsp_type rsp
);

   logic [amsc_pkg::RAD_W-1:0]  val_ff;
   logic [amsc_pkg::ROOT_W:0]   rem_ff;
   logic [amsc_pkg::ROOT_W-1:0] root_ff;
   logic [amsc_pkg::ITER_W-1:0] iter_ff;
   logic                        busy_ff;
   logic                        done_ff;
   logic [amsc_pkg::ROOT_W+2:0] cand;
   logic [amsc_pkg::ROOT_W+2:0] trial;
   logic                        fits;

   always_comb begin
      cand  = {rem_ff, val_ff[amsc_pkg::RAD_W-1 -: 2]};
      trial = {1'b0, root_ff, 2'b01};
      fits  = (cand >= trial);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            val_ff  <= req.radicand;
            rem_ff  <= '0;
            root_ff <= '0;
            iter_ff <= '0;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            val_ff  <= {val_ff[amsc_pkg::RAD_W-3:0], 2'b00};
            if (fits) begin
               rem_ff <= (amsc_pkg::ROOT_W + 1)'(cand - trial);
            end else begin
               rem_ff <= cand[amsc_pkg::ROOT_W:0];
            end
            root_ff <= {root_ff[amsc_pkg::ROOT_W-2:0], fits};
            iter_ff <= iter_ff + 1'b1;
            if (iter_ff == amsc_pkg::ITER_W'(amsc_pkg::ROOT_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign rsp.done = done_ff;
   assign rsp.root = root_ff;

endmodule

// File: rtl/core/amsc_back.sv
// Back end: window rings, rounded means, squared magnitude, step detection and count.
module amsc_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   item_valid,
   input  amsc_pkg::item_type     item,
   output logic                   pop,
   input  amsc_pkg::cfg_type      cfg,
   output amsc_pkg::sqrt_req_type sqrt_req,
   input  amsc_pkg::sqrt_rsp_type sqrt_rsp,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output amsc_pkg::result_type   rsp_data
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SUM,
      ST_MEAN,
      ST_DIV,
      ST_FIX,
      ST_SQ,
      ST_ADD,
      ST_ROOT,
      ST_DONE
   } state_type;

   localparam int A = amsc_pkg::NUM_AXES;

   state_type                       state_ff;
   logic [amsc_pkg::ACCEL_W-1:0]    ring_ff [A][amsc_pkg::WINDOW];
   logic [amsc_pkg::SLOT_W-1:0]     slot_ff;
   logic [amsc_pkg::SLOT_W-1:0]     idx_ff;
   logic [amsc_pkg::SUM_W-1:0]      acc_ff  [A];
   logic [amsc_pkg::SUM_W-1:0]      abs_ff  [A];
   logic [amsc_pkg::MEAN_W-1:0]     quot_ff [A];
   logic [amsc_pkg::MEAN_W-1:0]     mean_ff [A];
   logic [amsc_pkg::SQ_W-1:0]       sq_ff   [A];
   logic                            is_sample_ff;
   amsc_pkg::kind_type              kind_ff;
   logic                            disarmed_ff;
   logic [amsc_pkg::COUNT_W-1:0]    count_ff;
   logic [amsc_pkg::ROOT_W-1:0]     mag_ff;
   amsc_pkg::sqrt_req_type          sqrt_req_ff;
   amsc_pkg::result_type            rsp_data_ff;
   logic                            rsp_valid_ff;

   logic [amsc_pkg::SUM_W-1:0]      acc_in  [A];
   logic [amsc_pkg::SUM_W-1:0]      abs_in  [A];
   logic [amsc_pkg::MEAN_W-1:0]     quot_in [A];
   logic [amsc_pkg::MEAN_W-1:0]     mean_in [A];
   logic [amsc_pkg::RAD_W-1:0]      rad_in;
   logic [amsc_pkg::COUNT_W-1:0]    count_in;
   logic                            disarmed_in;
   logic                            hit;
   logic [amsc_pkg::DIST_W-1:0]     dist_in;
   logic                            slot_last;
   logic                            idx_last;
   logic                            out_free;

   assign pop       = (state_ff == ST_IDLE) && item_valid;
   assign slot_last = (slot_ff == amsc_pkg::SLOT_W'(amsc_pkg::WINDOW - 1));
   assign idx_last  = (idx_ff == amsc_pkg::SLOT_W'(amsc_pkg::WINDOW - 1));
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      logic [amsc_pkg::ACCEL_W-1:0]            elem;
      logic [amsc_pkg::SUM_W+1:0]              twice;
      logic [amsc_pkg::SUM_W+1:0]              twice_mag;
      logic [amsc_pkg::SUM_W+amsc_pkg::RECIP_W-1:0] prod;
      logic [amsc_pkg::SUM_W-1:0]              back_mul;
      logic [amsc_pkg::SUM_W-1:0]              rem;
      for (int a = 0; a < A; a++) begin
         elem       = ring_ff[a][idx_ff];
         acc_in[a]  = acc_ff[a] + {{(amsc_pkg::SUM_W - amsc_pkg::ACCEL_W){elem[amsc_pkg::ACCEL_W-1]}},
                                   elem};
         twice      = {acc_ff[a][amsc_pkg::SUM_W-1], acc_ff[a], 1'b0}
                      + (amsc_pkg::SUM_W + 2)'(amsc_pkg::WINDOW);
         twice_mag  = twice[amsc_pkg::SUM_W+1] ? (~twice + 1'b1) : twice;
         abs_in[a]  = twice_mag[amsc_pkg::SUM_W:1];
         prod       = amsc_pkg::SUM_W'(abs_ff[a]) * amsc_pkg::RECIP;
         quot_in[a] = prod[amsc_pkg::RECIP_SHIFT +: amsc_pkg::MEAN_W];
         back_mul   = amsc_pkg::SUM_W'(quot_ff[a]) * amsc_pkg::SUM_W'(amsc_pkg::WINDOW);
         rem        = abs_ff[a] - back_mul;
         mean_in[a] = (rem >= amsc_pkg::SUM_W'(amsc_pkg::WINDOW)) ? quot_ff[a] + 1'b1
                                                                   : quot_ff[a];
      end
   end

   always_comb begin
      rad_in = '0;
      for (int a = 0; a < A; a++) begin
         rad_in = rad_in + amsc_pkg::RAD_W'(sq_ff[a]);
      end
   end

   always_comb begin
      logic [amsc_pkg::COUNT_W:0] add_sum;
      add_sum     = {1'b0, count_ff} + {1'b0, amsc_pkg::ADD_AMOUNT};
      hit         = is_sample_ff && !disarmed_ff
                    && (mag_ff > amsc_pkg::ROOT_W'(cfg.step_threshold));
      disarmed_in = is_sample_ff ? hit : disarmed_ff;
      count_in    = count_ff;
      case (kind_ff)
         amsc_pkg::KIND_SAMPLE: begin
            if (hit && count_ff != amsc_pkg::COUNT_MAX) begin
               count_in = count_ff + 1'b1;
            end
         end
         amsc_pkg::KIND_CLEAR: count_in = '0;
         amsc_pkg::KIND_SUB: begin
            count_in = (count_ff > amsc_pkg::SUB_AMOUNT) ? count_ff - amsc_pkg::SUB_AMOUNT : '0;
         end
         amsc_pkg::KIND_ADD: begin
            count_in = (add_sum > {1'b0, amsc_pkg::COUNT_MAX}) ? amsc_pkg::COUNT_MAX
                                                                 : add_sum[amsc_pkg::COUNT_W-1:0];
         end
         default: count_in = count_ff;
      endcase
      dist_in = amsc_pkg::DIST_W'(count_in) * amsc_pkg::DIST_W'(cfg.stride_length);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_IDLE;
         slot_ff           <= '0;
         disarmed_ff       <= 1'b0;
         count_ff          <= '0;
         rsp_valid_ff      <= 1'b0;
         sqrt_req_ff.start <= 1'b0;
         for (int a = 0; a < A; a++) begin
            for (int w = 0; w < amsc_pkg::WINDOW; w++) begin
               ring_ff[a][w] <= '0;
            end
         end
      end else begin
         sqrt_req_ff.start <= (state_ff == ST_ADD);
         if ((state_ff == ST_DONE) && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (item_valid) begin
                  kind_ff      <= item.kind;
                  is_sample_ff <= item.is_sample;
                  mag_ff       <= '0;
                  idx_ff       <= '0;
                  for (int a = 0; a < A; a++) begin
                     acc_ff[a] <= '0;
                  end
                  if (item.is_sample) begin
                     for (int a = 0; a < A; a++) begin
                        ring_ff[a][slot_ff] <= item.accel[a];
                     end
                     slot_ff  <= slot_last ? '0 : slot_ff + 1'b1;
                     state_ff <= ST_SUM;
                  end else begin
                     state_ff <= ST_DONE;
                  end
               end
            end
            ST_SUM: begin
               acc_ff <= acc_in;
               idx_ff <= idx_ff + 1'b1;
               if (idx_last) begin
                  state_ff <= ST_MEAN;
               end
            end
            ST_MEAN: begin
               abs_ff   <= abs_in;
               state_ff <= ST_DIV;
            end
            ST_DIV: begin
               quot_ff  <= quot_in;
               state_ff <= ST_FIX;
            end
            ST_FIX: begin
               mean_ff  <= mean_in;
               state_ff <= ST_SQ;
            end
            ST_SQ: begin
               for (int a = 0; a < A; a++) begin
                  sq_ff[a] <= mean_ff[a] * mean_ff[a];
               end
               state_ff <= ST_ADD;
            end
            ST_ADD: begin
               sqrt_req_ff.radicand <= rad_in;
               state_ff             <= ST_ROOT;
            end
            ST_ROOT: begin
               if (sqrt_rsp.done) begin
                  mag_ff   <= sqrt_rsp.root;
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (out_free) begin
                  rsp_data_ff.magnitude     <= mag_ff[amsc_pkg::MAG_W-1:0];
                  rsp_data_ff.step_detected <= hit;
                  rsp_data_ff.step_total    <= count_in;
                  rsp_data_ff.distance      <= dist_in;
                  count_ff                  <= count_in;
                  disarmed_ff               <= disarmed_in;
                  state_ff                  <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign sqrt_req  = sqrt_req_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: rtl/core/accel_magnitude_step_counter.sv
// A sample goes through the back-end states SUM, MEAN, DIV, FIX, SQ, ADD, ROOT and DONE,
// a command through DONE only. The back end sums the rings one entry per cycle and the
// square root resolves one bit per cycle, and it works on one item at a time.
// A two-entry queue accepts transfers until it is full while the back end is busy or a result waits.
// Reset (synchronous, active high) clears rings, write slot, detector, count and queue, and
// restores the threshold to 300 and the stride to 9.
module accel_magnitude_step_counter (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [amsc_pkg::KIND_W-1:0]       req_tuser,  // kind
   input  logic [amsc_pkg::REQ_DATA_W-1:0]   req_tdata,  // accel_x, accel_y, accel_z
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // magnitude, step_detected, step_total, distance, zero pad
   output logic [amsc_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [amsc_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [amsc_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [amsc_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);

   amsc_pkg::cfg_type      cfg;
   amsc_pkg::item_type     item;
   logic                   item_valid;
   logic                   pop;
   amsc_pkg::sqrt_req_type sqrt_req;
   amsc_pkg::sqrt_rsp_type sqrt_rsp;
   amsc_pkg::result_type   rsp_data;

   amsc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   amsc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .pop        (pop),
      .item_valid (item_valid),
      .item       (item)
   );

   amsc_sqrt u_sqrt (
      .clock (clock),
      .reset (reset),
      .req   (sqrt_req),
      .rsp   (sqrt_rsp)
   );

   amsc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .pop        (pop),
      .cfg        (cfg),
      .sqrt_req   (sqrt_req),
      .sqrt_rsp   (sqrt_rsp),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_data   (rsp_data)
   );

   assign rsp_tdata = {{amsc_pkg::RSP_PAD_W{1'b0}}, rsp_data};

endmodule

// File: rtl/core/amsc_checker.sv
// Port-level checks of the step counter, bound to the top level.
module amsc_props (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [amsc_pkg::RSP_DATA_W-1:0]   rsp_tdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result offered right after reset");

   a_step_has_mag: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[16] |-> rsp_tdata[15:0] != 16'd0)
      else $error("step reported with zero magnitude");

   a_zero_distance: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[36:17] == 20'd0 |-> rsp_tdata[60:37] == 24'd0)
      else $error("distance without steps");

endmodule

bind accel_magnitude_step_counter amsc_props u_amsc_props (.*);

// File: sim/amsc_checker.sv
// Checker for the accelerometer step counter: predicts each result and compares every transfer.
module amsc_checker
   import amsc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [KIND_W-1:0]     req_tuser,  // kind
   input  logic [REQ_DATA_W-1:0] req_tdata,  // accel_x, accel_y, accel_z
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // magnitude, step_detected, step_total, distance, zero pad
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   input  logic [CSR_DATA_W-1:0] csr_prdata,
   input  logic                  csr_pready,
   output int                    mismatch_count,
   output int                    outcomes_waiting
);

   logic signed [ACCEL_W-1:0] axis_ring [NUM_AXES][WINDOW];
   int                        next_slot;
   logic                      disarmed;
   logic [COUNT_W-1:0]        step_count;
   logic [THRESH_W-1:0]       threshold;
   logic [STRIDE_W-1:0]       stride;
   result_type                outcomes_due [$];

   initial begin
      mismatch_count   = 0;
      outcomes_waiting = 0;
   end

   function automatic logic [MAG_W-1:0] floor_root(input longint radicand);
      logic [MAG_W:0] root;
      logic [MAG_W:0] trial;
      int             b;
      root = '0;
      for (b = MAG_W; b >= 0; b--) begin
         trial    = root;
         trial[b] = 1'b1;
         if (longint'(trial) * longint'(trial) <= radicand) begin
            root = trial;
         end
      end
      return root[MAG_W-1:0];
   endfunction

   function automatic result_type compute_step_outcome(input kind_type kind,
                                                       input logic [REQ_DATA_W-1:0] axes);
      result_type outcome;
      longint     axis_sum;
      longint     axis_mean;
      longint     square_sum;
      int         a;
      int         i;
      outcome = '0;
      case (kind)
         KIND_SAMPLE: begin
            square_sum = 0;
            for (a = 0; a < NUM_AXES; a++) begin
               axis_ring[a][next_slot] = axes[a*ACCEL_W +: ACCEL_W];
               axis_sum = 0;
               for (i = 0; i < WINDOW; i++) begin
                  axis_sum += axis_ring[a][i];
               end
               axis_mean   = (2 * axis_sum + WINDOW) / 2 / WINDOW;
               square_sum += axis_mean * axis_mean;
            end
            next_slot = (next_slot + 1) % WINDOW;
            outcome.magnitude = floor_root(square_sum);
            if (outcome.magnitude > threshold && !disarmed) begin
               disarmed              = 1'b1;
               outcome.step_detected = 1'b1;
               if (step_count != COUNT_MAX) begin
                  step_count++;
               end
            end else begin
               disarmed = 1'b0;
            end
         end
         KIND_CLEAR: begin
            step_count = '0;
         end
         KIND_SUB: begin
            step_count = (step_count > SUB_AMOUNT) ? step_count - SUB_AMOUNT : '0;
         end
         default: begin
            step_count = (step_count > COUNT_MAX - ADD_AMOUNT) ? COUNT_MAX
                                                               : step_count + ADD_AMOUNT;
         end
      endcase
      outcome.step_total = step_count;
      outcome.distance   = DIST_W'(longint'(step_count) * longint'(stride));
      return outcome;
   endfunction

   always @(posedge clock) begin : watch
      result_type            seen;
      result_type            due;
      logic [CSR_DATA_W-1:0] reg_value;
      int                    reg_index;
      int                    a;
      int                    i;
      if (reset) begin
         for (a = 0; a < NUM_AXES; a++) begin
            for (i = 0; i < WINDOW; i++) begin
               axis_ring[a][i] = '0;
            end
         end
         next_slot  = 0;
         disarmed   = 1'b0;
         step_count = '0;
         threshold  = THRESH_RESET;
         stride     = STRIDE_RESET;
         outcomes_due.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pready) begin
            reg_index = int'(csr_paddr >> 2);
            if (csr_pwrite) begin
               if (reg_index == int'(REG_STEP_THRESHOLD)) begin
                  threshold = csr_pwdata[THRESH_W-1:0];
               end else if (reg_index == int'(REG_STRIDE_LENGTH)) begin
                  stride = csr_pwdata[STRIDE_W-1:0];
               end
            end else begin
               reg_value = (reg_index == int'(REG_STEP_THRESHOLD)) ? CSR_DATA_W'(threshold)
                                                                   : CSR_DATA_W'(stride);
               if (csr_prdata !== reg_value) begin
                  $error("csr_prdata: expected %0d, actual %0d", reg_value, csr_prdata);
                  mismatch_count++;
               end
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            seen = result_type'(rsp_tdata[$bits(result_type)-1:0]);
            if (outcomes_due.size() == 0) begin
               $error("result transfer with no result due: magnitude %0d, step_total %0d",
                      seen.magnitude, seen.step_total);
               mismatch_count++;
            end else begin
               due = outcomes_due.pop_front();
               if (seen.magnitude !== due.magnitude) begin
                  $error("magnitude: expected %0d, actual %0d", due.magnitude, seen.magnitude);
                  mismatch_count++;
               end
               if (seen.step_detected !== due.step_detected) begin
                  $error("step_detected: expected %0d, actual %0d",
                         due.step_detected, seen.step_detected);
                  mismatch_count++;
               end
               if (seen.step_total !== due.step_total) begin
                  $error("step_total: expected %0d, actual %0d",
                         due.step_total, seen.step_total);
                  mismatch_count++;
               end
               if (seen.distance !== due.distance) begin
                  $error("distance: expected %0d, actual %0d", due.distance, seen.distance);
                  mismatch_count++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            outcomes_due.push_back(compute_step_outcome(kind_type'(req_tuser), req_tdata));
         end
      end
      outcomes_waiting <= outcomes_due.size();
   end

endmodule

// File: sim/tb_accel_magnitude_step_counter.sv
// Testbench top for the accelerometer step counter: stimulus, flow control and the verdict.
module tb_accel_magnitude_step_counter;
   import amsc_pkg::*;

   localparam int CYCLE_LIMIT     = 1000000;
   localparam int SETTLE_CYCLES   = 40;
   localparam int COUNT_ADDS      = 8;
   localparam logic [ACCEL_W-1:0] BOUNDARY [4] = '{16'h8000, 16'h7FFF, 16'h0000, 16'h0001};

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [KIND_W-1:0]     req_tuser   = '0;  // kind
   logic [REQ_DATA_W-1:0] req_tdata   = '0;  // accel_x, accel_y, accel_z
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   // magnitude, step_detected, step_total, distance, zero pad
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   int          current_threshold = int'(THRESH_RESET);
   int unsigned cycle_count = 0;
   int          mismatch_count;
   int          outcomes_waiting;
   int          n;

   accel_magnitude_step_counter u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tuser   (req_tuser),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   amsc_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_tvalid       (req_tvalid),
      .req_tready       (req_tready),
      .req_tuser        (req_tuser),
      .req_tdata        (req_tdata),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_tdata        (rsp_tdata),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready),
      .mismatch_count   (mismatch_count),
      .outcomes_waiting (outcomes_waiting)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // call at a falling edge; returns at the falling edge after the transfer
   task automatic send_item(input kind_type kind, input logic [ACCEL_W-1:0] ax,
                            input logic [ACCEL_W-1:0] ay, input logic [ACCEL_W-1:0] az);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {az, ay, ax};
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      @(negedge clock);
   endtask

   task automatic csr_access(input logic is_write, input reg_index_type index,
                             input logic [CSR_DATA_W-1:0] value);
      req_tvalid  <= 1'b0;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= is_write;
      csr_paddr   <= CSR_ADDR_W'(4 * int'(index));
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) begin
         @(posedge clock);
      end
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (is_write && index == REG_STEP_THRESHOLD) begin
         current_threshold = int'(value[THRESH_W-1:0]);
      end
   endtask

   task automatic configure(input int thresh, input int stride_units);
      csr_access(1'b1, REG_STEP_THRESHOLD, CSR_DATA_W'(thresh));
      csr_access(1'b1, REG_STRIDE_LENGTH, CSR_DATA_W'(stride_units));
      csr_access(1'b0, REG_STEP_THRESHOLD, '0);
      csr_access(1'b0, REG_STRIDE_LENGTH, '0);
   endtask

   // wait for every result due, then let the back end go quiet
   task automatic settle();
      req_tvalid <= 1'b0;
      while (outcomes_waiting != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // mostly walking patterns: runs above and below the threshold with random content
   task automatic run_random(input int target);
      int                 sent;
      int                 pick;
      int                 run_len;
      int                 j;
      int                 a;
      int                 amp;
      int                 top_amp;
      bit                 heavy;
      logic [NUM_AXES-1:0] negative;
      logic [ACCEL_W-1:0] v [NUM_AXES];
      sent  = 0;
      heavy = 1'b0;
      while (sent < target) begin
         pick = $urandom_range(99);
         if (pick < 12) begin
            send_item(kind_type'($urandom_range(int'(KIND_CLEAR), int'(KIND_ADD))),
                      ACCEL_W'($urandom), ACCEL_W'($urandom), ACCEL_W'($urandom));
            sent++;
         end else if (pick < 25) begin
            send_item(KIND_SAMPLE, ACCEL_W'($urandom), ACCEL_W'($urandom), ACCEL_W'($urandom));
            sent++;
         end else if (pick < 30) begin
            send_item(KIND_SAMPLE, BOUNDARY[$urandom_range(3)], BOUNDARY[$urandom_range(3)],
                      BOUNDARY[$urandom_range(3)]);
            sent++;
         end else begin
            heavy    = !heavy;
            run_len  = $urandom_range(2, 8);
            negative = NUM_AXES'($urandom);
            top_amp  = (current_threshold > 32767) ? 32767 : current_threshold;
            for (j = 0; j < run_len && sent < target; j++) begin
               for (a = 0; a < NUM_AXES; a++) begin
                  amp  = heavy ? $urandom_range(top_amp, 32767) : $urandom_range(top_amp / 4);
                  v[a] = negative[a] ? ACCEL_W'(-amp) : ACCEL_W'(amp);
               end
               send_item(KIND_SAMPLE, v[0], v[1], v[2]);
               sent++;
            end
         end
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 36;
      recv_idle_pct = 72;
      csr_access(1'b0, REG_STEP_THRESHOLD, '0);
      csr_access(1'b0, REG_STRIDE_LENGTH, '0);
      send_item(KIND_SAMPLE, 16'h0000, 16'h0000, 16'h0000);
      repeat (3) send_item(KIND_SAMPLE, 16'h7FFF, 16'h7FFF, 16'h7FFF);
      send_item(KIND_SUB, 16'hFFFF, 16'h0000, 16'hFFFF);
      repeat (6) send_item(KIND_ADD, 16'h0000, 16'hFFFF, 16'h0000);
      send_item(KIND_SUB, 16'h5555, 16'hAAAA, 16'h5555);
      send_item(KIND_CLEAR, 16'hAAAA, 16'h5555, 16'hAAAA);
      repeat (5) send_item(KIND_SAMPLE, 16'h8000, 16'h8000, 16'h8000);
      send_item(KIND_SAMPLE, 16'h7FFF, 16'h8000, 16'h0001);
      settle();

      configure(65535, 0);
      repeat (2) send_item(KIND_SAMPLE, 16'h8000, 16'h8000, 16'h8000);
      send_item(KIND_ADD, 16'h0000, 16'h0000, 16'h0000);
      settle();

      configure($urandom_range(500, 20000), 1);
      run_random(120);
      settle();

      send_idle_pct = 72;
      recv_idle_pct = 36;
      configure($urandom_range(500, 20000), $urandom_range(1, 15));
      run_random(120);
      settle();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      configure($urandom_range(500, 20000), $urandom_range(1, 15));
      run_random(120);
      settle();

      // build the count up with adds, count steps on top, then drop it back
      configure(0, 15);
      send_item(KIND_CLEAR, ACCEL_W'($urandom), ACCEL_W'($urandom), ACCEL_W'($urandom));
      for (n = 0; n < COUNT_ADDS; n++) begin
         send_item(KIND_ADD, ACCEL_W'($urandom), ACCEL_W'($urandom), ACCEL_W'($urandom));
      end
      repeat (5) send_item(KIND_SAMPLE, 16'h0000, 16'h0000, 16'h0000);
      repeat (3) send_item(KIND_SAMPLE, 16'h7FFF, 16'h7FFF, 16'h7FFF);
      send_item(KIND_SUB, ACCEL_W'($urandom), ACCEL_W'($urandom), ACCEL_W'($urandom));
      send_item(KIND_CLEAR, ACCEL_W'($urandom), ACCEL_W'($urandom), ACCEL_W'($urandom));
      settle();

      if (mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
